// ===== src/gdr_pkg.sv =====
// Shared types, widths and constants for the grid DDA ray caster.
`default_nettype none
package gdr_pkg;

    // Block sizes
    localparam int SCREEN_WIDTH = 640;
    localparam int MAP_SIDE     = 64;
    localparam int STEP_CAP     = 300;
    localparam int ONE_Q16      = 65536;

    // Field and datapath widths
    localparam int CFG_W      = 22;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 12;
    localparam int CELL_W     = 6;
    localparam int VAL_W      = 8;
    localparam int DIST_W     = 24;
    localparam int COL_W      = 10;
    localparam int COORD_W    = 8;   // signed map coordinate, one step past either edge
    localparam int CAM_W      = 28;  // signed camera offset, Q.16
    localparam int PM_W       = 16 + CAM_W;
    localparam int RAY_W      = 29;  // signed ray component, Q.14
    localparam int ABS_W      = 28;
    localparam int T_W        = 25;  // boundary distance, Q.16, up to STEP_CAP steps
    localparam int PROD_W     = T_W + ABS_W;
    localparam int NUM_W      = 26;
    localparam int AN_W       = 25;
    localparam int DVD_W      = 38;
    localparam int DVS_W      = 28;
    localparam int DIV_CNT_W  = $clog2(DVD_W);
    localparam int STEP_CNT_W = $clog2(STEP_CAP);

    // Camera offset: 2*column*ONE/width = column*CAM_Q + column*CAM_R/width,
    // the second term by reciprocal multiplication (exact for column*CAM_R < 2^20)
    localparam int     CAM_Q     = (2 * ONE_Q16) / SCREEN_WIDTH;
    localparam int     CAM_R     = (2 * ONE_Q16) % SCREEN_WIDTH;
    localparam int     CAM_LO_W  = 20;
    localparam int     CAM_SH    = 30;
    localparam int     RECIP_W   = 21;
    localparam longint CAM_RECIP = ((longint'(1) << CAM_SH) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;

    localparam logic [DIST_W-1:0]         DIST_MAX   = '1;
    localparam logic [ADDR_W-1:0]         ADDR_LAST  = '1;
    localparam logic signed [COORD_W-1:0] MAP_SIDE_C = COORD_W'(MAP_SIDE);
    localparam logic [STEP_CNT_W-1:0]     STEP_LAST  = STEP_CNT_W'(STEP_CAP - 1);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] DIR_X_RST   = 16'd16384;
    localparam logic [15:0] DIR_Y_RST   = 16'd0;
    localparam logic [15:0] PLANE_X_RST = 16'd0;
    localparam logic [15:0] PLANE_Y_RST = 16'd10813;

    // Input operations
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_CAST  = 1'b1
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM_DIV,
        ST_RAY_MUL,
        ST_RAY,
        ST_INIT_MUL,
        ST_STEP,
        ST_CHECK,
        ST_PERP,
        ST_PERP_WAIT,
        ST_FINISH
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/gdr_map_mem.sv =====
// Map cell memory: one write port, one registered read port.
`default_nettype none
module gdr_map_mem
    import gdr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [VAL_W-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [VAL_W-1:0]  rd_data
);

    logic [VAL_W-1:0] mem [0:(1 << ADDR_W) - 1];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/gdr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module gdr_div
    import gdr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

// ===== src/grid_dda_ray_caster.sv =====
// Grid DDA ray caster: a cell-map write or a ray cast through the map.
// A cast walks at most 300 steps (steps <= 300); a zero ray does not walk.
// The camera offset is a short reciprocal multiply, the wall distance a serial
// division, and each DDA step is a map read followed by a check.
// One item is in work at a time; a finished result waits in the output register.
// After reset the map is cleared cell by cell; no item is accepted until then.
`default_nettype none
module grid_dda_ray_caster
    import gdr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    // input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_operation,
    input  wire logic [COL_W-1:0]  s_column,
    input  wire logic [CELL_W-1:0] s_cell_x,
    input  wire logic [CELL_W-1:0] s_cell_y,
    input  wire logic [VAL_W-1:0]  s_cell_value,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DIST_W-1:0]      m_perp_distance,
    output logic                   m_hit_side,
    output logic [CELL_W-1:0]      m_hit_x,
    output logic [CELL_W-1:0]      m_hit_y,
    output logic [VAL_W-1:0]       m_hit_value,
    output logic                   m_out_of_map
);

    // Configuration registers
    logic [CFG_W-1:0] pos_x_reg, pos_y_reg;
    logic [15:0]      dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= DIR_X_RST;
            dir_y_reg   <= DIR_Y_RST;
            plane_x_reg <= PLANE_X_RST;
            plane_y_reg <= PLANE_Y_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POS_X:   pos_x_reg   <= cfg_wr_data;
                REG_POS_Y:   pos_y_reg   <= cfg_wr_data;
                REG_DIR_X:   dir_x_reg   <= cfg_wr_data[15:0];
                REG_DIR_Y:   dir_y_reg   <= cfg_wr_data[15:0];
                REG_PLANE_X: plane_x_reg <= cfg_wr_data[15:0];
                REG_PLANE_Y: plane_y_reg <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic signed [CAM_W-1:0]    cam_reg, cam_next;
    logic [CAM_LO_W-1:0]        cam_lo_reg, cam_lo_next;
    logic signed [PM_W-1:0]     pmx_reg, pmx_next, pmy_reg, pmy_next;
    logic                       rx_neg_reg, rx_neg_next, ry_neg_reg, ry_neg_next;
    logic [ABS_W-1:0]           ax_reg, ax_next, ay_reg, ay_next;
    logic [T_W-1:0]             tx_reg, tx_next, ty_reg, ty_next;
    logic [PROD_W-1:0]          px_reg, px_next, qy_reg, qy_next;
    logic signed [COORD_W-1:0]  mx_reg, mx_next, my_reg, my_next;
    logic                       side_reg, side_next;
    logic                       oom_reg, oom_next;
    logic [VAL_W-1:0]           value_reg, value_next;
    logic [STEP_CNT_W-1:0]      step_cnt_reg, step_cnt_next;
    logic [DIST_W-1:0]          dist_reg, dist_next;

    // Output registers
    logic                       m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]          m_dist_reg, m_dist_next;
    logic                       m_side_reg, m_side_next;
    logic [CELL_W-1:0]          m_hx_reg, m_hx_next, m_hy_reg, m_hy_next;
    logic [VAL_W-1:0]           m_val_reg, m_val_next;
    logic                       m_oom_reg, m_oom_next;

    // Memory and divider connections
    logic                       mem_we, mem_re;
    logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
    logic [VAL_W-1:0]           mem_wdata, mem_rdata;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    // Combinational helpers
    logic signed [RAY_W-1:0]    rx_w, ry_w;
    logic                       step_x_w, in_map_w;
    logic signed [COORD_W-1:0]  nmx_w, nmy_w, pcell_w;
    logic                       pneg_w;
    logic [CFG_W-1:0]           ppos_w;
    logic signed [NUM_W-1:0]    bound_w, num_w;
    logic [AN_W-1:0]            an_w;
    logic [CAM_LO_W+RECIP_W-1:0] cam_fix_w;

    gdr_map_mem u_map (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    gdr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Fractional part of the camera offset by reciprocal multiply
    assign cam_fix_w = (CAM_LO_W+RECIP_W)'(cam_lo_reg)
                     * (CAM_LO_W+RECIP_W)'(CAM_RECIP);

    // Ray components from the registered plane products
    assign rx_w = RAY_W'($signed(dir_x_reg)) + RAY_W'(pmx_reg >>> 16);
    assign ry_w = RAY_W'($signed(dir_y_reg)) + RAY_W'(pmy_reg >>> 16);

    // DDA step choice and next cell
    assign step_x_w = (px_reg < qy_reg);
    assign nmx_w = !step_x_w ? mx_reg : (rx_neg_reg ? mx_reg - 8'sd1 : mx_reg + 8'sd1);
    assign nmy_w = step_x_w ? my_reg : (ry_neg_reg ? my_reg - 8'sd1 : my_reg + 8'sd1);
    assign in_map_w = (nmx_w >= 8'sd0) && (nmx_w < MAP_SIDE_C)
                   && (nmy_w >= 8'sd0) && (nmy_w < MAP_SIDE_C);

    // Distance numerator for the axis crossed last
    assign pcell_w = side_reg ? my_reg : mx_reg;
    assign pneg_w  = side_reg ? ry_neg_reg : rx_neg_reg;
    assign ppos_w  = side_reg ? pos_y_reg : pos_x_reg;
    assign bound_w = (NUM_W'(pcell_w) + $signed({{(NUM_W-1){1'b0}}, pneg_w})) <<< 16;
    assign num_w   = bound_w - $signed({{(NUM_W-CFG_W){1'b0}}, ppos_w});
    assign an_w    = num_w[NUM_W-1] ? AN_W'(-num_w) : AN_W'(num_w);

    // Next state and datapath
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cam_next      = cam_reg;
        cam_lo_next   = cam_lo_reg;
        pmx_next      = pmx_reg;
        pmy_next      = pmy_reg;
        rx_neg_next   = rx_neg_reg;
        ry_neg_next   = ry_neg_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        tx_next       = tx_reg;
        ty_next       = ty_reg;
        px_next       = px_reg;
        qy_next       = qy_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        side_next     = side_reg;
        oom_next      = oom_reg;
        value_next    = value_reg;
        step_cnt_next = step_cnt_reg;
        dist_next     = dist_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_dist_next   = m_dist_reg;
        m_side_next   = m_side_reg;
        m_hx_next     = m_hx_reg;
        m_hy_next     = m_hy_reg;
        m_val_next    = m_val_reg;
        m_oom_next    = m_oom_reg;
        mem_we        = 1'b0;
        mem_waddr     = {s_cell_x, s_cell_y};
        mem_wdata     = s_cell_value;
        mem_re        = 1'b0;
        mem_raddr     = {nmx_w[CELL_W-1:0], nmy_w[CELL_W-1:0]};
        div_req       = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_WRITE) begin
                        mem_we = ({2'b00, s_cell_x} < MAP_SIDE_C)
                              && ({2'b00, s_cell_y} < MAP_SIDE_C);
                    end else begin
                        // whole part of the camera offset, remainder term kept
                        cam_next    = $signed(CAM_W'(s_column) * CAM_W'(CAM_Q)
                                              - CAM_W'(ONE_Q16));
                        cam_lo_next = CAM_LO_W'(s_column) * CAM_LO_W'(CAM_R);
                        state_next  = ST_CAM_DIV;
                    end
                end
            end
            ST_CAM_DIV: begin
                cam_next   = cam_reg + $signed(CAM_W'(cam_fix_w >> CAM_SH));
                state_next = ST_RAY_MUL;
            end
            ST_RAY_MUL: begin
                pmx_next   = $signed(plane_x_reg) * cam_reg;
                pmy_next   = $signed(plane_y_reg) * cam_reg;
                state_next = ST_RAY;
            end
            ST_RAY: begin
                rx_neg_next   = rx_w[RAY_W-1];
                ry_neg_next   = ry_w[RAY_W-1];
                ax_next       = rx_w[RAY_W-1] ? ABS_W'(-rx_w) : ABS_W'(rx_w);
                ay_next       = ry_w[RAY_W-1] ? ABS_W'(-ry_w) : ABS_W'(ry_w);
                tx_next       = rx_w[RAY_W-1] ? T_W'(pos_x_reg[15:0])
                                              : T_W'(ONE_Q16) - T_W'(pos_x_reg[15:0]);
                ty_next       = ry_w[RAY_W-1] ? T_W'(pos_y_reg[15:0])
                                              : T_W'(ONE_Q16) - T_W'(pos_y_reg[15:0]);
                mx_next       = $signed({2'b00, pos_x_reg[CFG_W-1:16]});
                my_next       = $signed({2'b00, pos_y_reg[CFG_W-1:16]});
                side_next     = 1'b0;
                step_cnt_next = '0;
                if (rx_w == '0 && ry_w == '0) begin
                    // no direction: no walk, saturated distance
                    dist_next  = DIST_MAX;
                    oom_next   = 1'b1;
                    value_next = '0;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_INIT_MUL;
                end
            end
            ST_INIT_MUL: begin
                px_next    = PROD_W'(tx_reg) * PROD_W'(ay_reg);
                qy_next    = PROD_W'(ty_reg) * PROD_W'(ax_reg);
                state_next = ST_STEP;
            end
            ST_STEP: begin
                // cross products advance by one cell span each step
                if (step_x_w) begin
                    px_next   = px_reg + (PROD_W'(ay_reg) << 16);
                    side_next = 1'b0;
                end else begin
                    qy_next   = qy_reg + (PROD_W'(ax_reg) << 16);
                    side_next = 1'b1;
                end
                mx_next = nmx_w;
                my_next = nmy_w;
                if (!in_map_w) begin
                    oom_next   = 1'b1;
                    value_next = '0;
                    state_next = ST_PERP;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (mem_rdata != '0) begin
                    oom_next   = 1'b0;
                    value_next = mem_rdata;
                    state_next = ST_PERP;
                end else if (step_cnt_reg == STEP_LAST) begin
                    oom_next   = 1'b1;
                    value_next = '0;
                    state_next = ST_PERP;
                end else begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_PERP: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'({an_w, 14'b0});
                div_req.divisor  = side_reg ? ay_reg : ax_reg;
                state_next       = ST_PERP_WAIT;
            end
            ST_PERP_WAIT: begin
                if (div_rsp.done) begin
                    dist_next  = (|div_rsp.quotient[DVD_W-1:DIST_W]) ? DIST_MAX
                                 : div_rsp.quotient[DIST_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_dist_next  = dist_reg;
                    m_side_next  = side_reg;
                    m_hx_next    = mx_reg[CELL_W-1:0];
                    m_hy_next    = my_reg[CELL_W-1:0];
                    m_val_next   = value_reg;
                    m_oom_next   = oom_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cam_reg      <= cam_next;
        cam_lo_reg   <= cam_lo_next;
        pmx_reg      <= pmx_next;
        pmy_reg      <= pmy_next;
        rx_neg_reg   <= rx_neg_next;
        ry_neg_reg   <= ry_neg_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        px_reg       <= px_next;
        qy_reg       <= qy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        side_reg     <= side_next;
        oom_reg      <= oom_next;
        value_reg    <= value_next;
        step_cnt_reg <= step_cnt_next;
        dist_reg     <= dist_next;
        m_dist_reg   <= m_dist_next;
        m_side_reg   <= m_side_next;
        m_hx_reg     <= m_hx_next;
        m_hy_reg     <= m_hy_next;
        m_val_reg    <= m_val_next;
        m_oom_reg    <= m_oom_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_perp_distance = m_dist_reg;
    assign m_hit_side      = m_side_reg;
    assign m_hit_x         = m_hx_reg;
    assign m_hit_y         = m_hy_reg;
    assign m_hit_value     = m_val_reg;
    assign m_out_of_map    = m_oom_reg;

`ifndef SYNTH
    // A finished division always moves the sequencer on
    a_perp_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PERP_WAIT && div_rsp.done) |=> (state_reg == ST_FINISH))
        else $error("distance division result dropped");

    // The walk never runs past its step cap
    a_step_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (step_cnt_reg <= STEP_LAST))
        else $error("DDA step count past cap");

    // A wall hit always reports a nonzero cell value
    a_hit_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_oom_reg) |-> (m_val_reg != '0))
        else $error("wall hit with empty cell");

    // A new result only comes from the finish step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the grid DDA ray caster.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: map and camera mirror, queue of predicted ray hits.
class ray_scoreboard;
    logic [7:0]         grid [4096];
    logic [21:0]        px, py;
    logic signed [15:0] dx, dy, plx, ply;
    logic [52:0]        hit_q [$];
    int                 errors;

    function new();
        foreach (grid[i]) grid[i] = 8'd0;
        px = '0; py = '0;
        dx = 16'sd16384; dy = 16'sd0; plx = 16'sd0; ply = 16'sd10813;
        errors = 0;
    endfunction

    function void set_reg(int idx, logic [21:0] v);
        case (idx)
            gdr_pkg::REG_POS_X:   px  = v;
            gdr_pkg::REG_POS_Y:   py  = v;
            gdr_pkg::REG_DIR_X:   dx  = v[15:0];
            gdr_pkg::REG_DIR_Y:   dy  = v[15:0];
            gdr_pkg::REG_PLANE_X: plx = v[15:0];
            gdr_pkg::REG_PLANE_Y: ply = v[15:0];
            default: ;
        endcase
    endfunction

    // floor(v / 65536) for signed v
    function longint fdiv16(longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function longint wall_dist(longint c, longint r, longint p);
        longint bnd, nm, ad, q;
        bnd = (c + (r < 0 ? 1 : 0)) * 65536;
        nm  = bnd - p;
        if (nm < 0) nm = -nm;
        ad = r < 0 ? -r : r;
        if (ad == 0) return 64'd16777215;
        q = (nm << 14) / ad;
        return q > 16777215 ? 16777215 : q;
    endfunction

    // Note an accepted input transaction.
    function void note_input(logic op, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                             logic [7:0] cv);
        longint cam, rx, ry, mx, my, ax, ay, tx, ty, stx, sty, dst, val;
        int side, oom;
        if (op == gdr_pkg::OP_WRITE) begin
            grid[{cx, cy}] = cv;
            return;
        end
        cam = (2 * longint'(col) * 65536) / gdr_pkg::SCREEN_WIDTH - 65536;
        rx = longint'(dx) + fdiv16(longint'(plx) * cam);
        ry = longint'(dy) + fdiv16(longint'(ply) * cam);
        mx = px >> 16; my = py >> 16;
        side = 0; val = 0; oom = 1;
        if (rx == 0 && ry == 0) begin
            dst = 16777215;
        end else begin
            ax = rx < 0 ? -rx : rx;
            ay = ry < 0 ? -ry : ry;
            stx = rx < 0 ? -1 : 1;
            sty = ry < 0 ? -1 : 1;
            tx = rx < 0 ? px[15:0] : 65536 - px[15:0];
            ty = ry < 0 ? py[15:0] : 65536 - py[15:0];
            for (int n = 0; n < 300; n++) begin
                if (tx * ay < ty * ax) begin
                    tx += 65536; mx += stx; side = 0;
                end else begin
                    ty += 65536; my += sty; side = 1;
                end
                if (mx < 0 || mx >= 64 || my < 0 || my >= 64) break;
                val = grid[mx * 64 + my];
                if (val > 0) begin
                    oom = 0;
                    break;
                end
            end
            if (oom) val = 0;
            dst = side == 0 ? wall_dist(mx, rx, px) : wall_dist(my, ry, py);
        end
        hit_q.push_back({dst[23:0], 1'(side), mx[5:0], my[5:0], val[7:0], 7'd0, 1'(oom)});
    endfunction

    // Compare one result transaction with the oldest prediction.
    function void check_hit(logic [52:0] got);
        logic [52:0] exp_v;
        if (hit_q.size() == 0) begin
            $display("%0t: unexpected result exp none got %h", $realtime, got);
            errors++;
            return;
        end
        exp_v = hit_q.pop_front();
        if (exp_v[52:29] !== got[52:29])
            $display("%0t: perp_distance exp %0d got %0d", $realtime, exp_v[52:29], got[52:29]);
        if (exp_v[28] !== got[28])
            $display("%0t: hit_side exp %0d got %0d", $realtime, exp_v[28], got[28]);
        if (exp_v[27:22] !== got[27:22])
            $display("%0t: hit_x exp %0d got %0d", $realtime, exp_v[27:22], got[27:22]);
        if (exp_v[21:16] !== got[21:16])
            $display("%0t: hit_y exp %0d got %0d", $realtime, exp_v[21:16], got[21:16]);
        if (exp_v[15:8] !== got[15:8])
            $display("%0t: hit_value exp %0d got %0d", $realtime, exp_v[15:8], got[15:8]);
        if (exp_v[0] !== got[0])
            $display("%0t: out_of_map exp %0d got %0d", $realtime, exp_v[0], got[0]);
        if (exp_v !== got) errors++;
    endfunction
endclass

module tb;
    import gdr_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_operation = 1'b0;
    logic [COL_W-1:0]  s_column = '0;
    logic [CELL_W-1:0] s_cell_x = '0;
    logic [CELL_W-1:0] s_cell_y = '0;
    logic [VAL_W-1:0]  s_cell_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DIST_W-1:0] m_perp_distance;
    logic              m_hit_side;
    logic [CELL_W-1:0] m_hit_x, m_hit_y;
    logic [VAL_W-1:0]  m_hit_value;
    logic              m_out_of_map;

    ray_scoreboard sb = new();
    int send_idle_pct = 33;
    int recv_idle_pct = 55;
    int hold_off      = 0;

    grid_dda_ray_caster dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Monitor: sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_operation, s_column, s_cell_x, s_cell_y, s_cell_value);
        if (aresetn && m_valid && m_ready)
            sb.check_hit({m_perp_distance, m_hit_side, m_hit_x, m_hit_y, m_hit_value,
                          7'd0, m_out_of_map});
    end

    // Result-side ready with random stalls and an optional long hold-off
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid stays up after acceptance until the next send or drain moves it
    task automatic send(logic op, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                        logic [7:0] cv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op; s_column <= col;
        s_cell_x <= cx; s_cell_y <= cy; s_cell_value <= cv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wall(int x, int y, int v);
        send(OP_WRITE, 10'($urandom), 6'(x), 6'(y), 8'(v));
    endtask

    task automatic cast(int col);
        send(OP_CAST, 10'(col), 6'($urandom), 6'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.hit_q.size() != 0) @(negedge aclk);
        repeat (800) @(negedge aclk);
    endtask

    task automatic set_reg(cfg_reg_t idx, logic [21:0] v);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, v);
        @(negedge aclk);
    endtask

    // Random camera: random position, direction and plane, plane x zero sometimes
    task automatic random_camera();
        set_reg(REG_POS_X, {6'($urandom_range(63)), 16'($urandom)});
        set_reg(REG_POS_Y, {6'($urandom_range(63)), 16'($urandom)});
        set_reg(REG_DIR_X, 22'($urandom));
        set_reg(REG_DIR_Y, 22'($urandom));
        set_reg(REG_PLANE_X, $urandom_range(3) == 0 ? 22'd0 : 22'($urandom));
        set_reg(REG_PLANE_Y, 22'($urandom));
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: default camera, empty map, then walls and edge cases
        cast(0); cast(639); cast(320); cast(1023);
        wall(1, 0, 255); wall(63, 63, 1); wall(0, 63, 128);
        cast(320); cast(0); cast(1023);
        drain();
        set_reg(REG_POS_X, 22'h3FFFFF); set_reg(REG_POS_Y, 22'h3FFFFF);
        set_reg(REG_DIR_X, 22'h8000);   set_reg(REG_DIR_Y, 22'h8000);
        set_reg(REG_PLANE_X, 22'h7FFF); set_reg(REG_PLANE_Y, 22'h7FFF);
        cast(0); cast(320); cast(639); cast(1023);
        drain();
        // zero ray, and one axis zero
        set_reg(REG_POS_X, 22'h20_8000); set_reg(REG_POS_Y, 22'h20_8000);
        set_reg(REG_DIR_X, 22'd0); set_reg(REG_DIR_Y, 22'd0);
        set_reg(REG_PLANE_X, 22'd0); set_reg(REG_PLANE_Y, 22'd0);
        cast(5);
        drain();
        set_reg(REG_DIR_Y, 22'd100);
        wall(32, 40, 9);
        cast(7); cast(0);
        drain();

        // Random phases with varied idling
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin send_idle_pct = 55; recv_idle_pct = 33; end
            if (ph == 8) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            random_camera();
            if (ph == 9) hold_off = 3000;
            for (int i = 0; i < 105; i++) begin
                if ($urandom_range(99) < 40)
                    wall($urandom_range(63), $urandom_range(63),
                         $urandom_range(3) == 0 ? 0 : $urandom_range(1, 255));
                else
                    cast($urandom_range(7) == 0 ? $urandom_range(1023)
                                                : $urandom_range(639));
            end
            drain();
        end

        if (sb.errors == 0 && sb.hit_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
src/gdr_pkg.sv
src/gdr_map_mem.sv
src/gdr_div.sv
src/grid_dda_ray_caster.sv
bench/tb.sv
